### sv/hstb_pkg.sv
// Package for the half-scale tile brighten block: item structs and fixed widths.
// No dependencies; imported by hstb_rem and half_scale_tile_brighten.
`default_nettype none
package hstb_pkg;

	localparam int CHAN_W  = 8;
	localparam int COORD_W = 16;
	localparam int SIZE_W  = 8;
	localparam int HALF_W  = SIZE_W - 1;
	localparam int SUM_W   = CHAN_W + 2;
	localparam int PIX_W   = 3 * CHAN_W;
	localparam int CIDX_W  = 2;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
	localparam logic [SIZE_W-1:0] SIZE_MIN = 8'd2;

	localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_BRIGHT = 2'd2;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic               action;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [CHAN_W-1:0]  pixel_red;
		logic [CHAN_W-1:0]  pixel_green;
		logic [CHAN_W-1:0]  pixel_blue;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
	} out_item_t;

endpackage
`default_nettype wire

### sv/hstb_rem.sv
// Iterative remainder unit: 16-bit coordinate modulo a 7-bit half size,
// two restoring steps per cycle. Depends on hstb_pkg.
`default_nettype none
module hstb_rem (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [hstb_pkg::COORD_W-1:0] dividend,
	input  wire logic [hstb_pkg::HALF_W-1:0]  divisor,
	output logic                            busy,
	output logic [hstb_pkg::HALF_W-1:0]     rem
);
	import hstb_pkg::*;

	localparam int STEPS = COORD_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	logic [COORD_W-1:0] sh_q;
	logic [HALF_W-1:0]  rem_q;
	logic [HALF_W-1:0]  div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic [HALF_W-1:0]  r1;
	logic [HALF_W-1:0]  r2;

	function automatic logic [HALF_W-1:0] rstep(input logic [HALF_W-1:0] r,
		input logic b, input logic [HALF_W-1:0] d);
		logic [HALF_W:0] t;
		t = {r, b};
		if (t >= {1'b0, d})
			t = t - {1'b0, d};
		return t[HALF_W-1:0];
	endfunction

	assign r1 = rstep(rem_q, sh_q[COORD_W-1], div_q);
	assign r2 = rstep(r1, sh_q[COORD_W-2], div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[COORD_W-3:0], 2'b00};
			rem_q <= r2;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

### sv/half_scale_tile_brighten.sv
// Top level: pixel store, query sequencer, 2x2 average and brightness add.
// Depends on hstb_pkg and hstb_rem.
//
//   channel | signals                         | direction
//   in      | in_valid, in_ready, in_data     | load or query item in
//   out     | out_valid, out_ready, out_data  | averaged pixel item out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// A load writes the store at its accept edge if its coordinates lie inside the clamped width and height.
// A query passes from ST_MOD (the two-bit-per-cycle remainder units and the block address)
// to ST_RD (reading the four pixels of the single-port store) and ST_FIN (forming the result,
// held while the output register is full); the next item is taken once back in ST_IDLE.
// Reset clears control state and loads the register defaults; the store is not cleared.
// A finished item waits in the output register; loads are still taken meanwhile.
`default_nettype none
module half_scale_tile_brighten #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire hstb_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output hstb_pkg::out_item_t                 out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [hstb_pkg::CIDX_W-1:0]    cfg_index,
	input  wire logic [hstb_pkg::SIZE_W-1:0]    cfg_data
);
	import hstb_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [SIZE_W-1:0] bright_q;
	logic [SIZE_W-1:0] eff_w;
	logic [SIZE_W-1:0] eff_h;
	logic [HALF_W-1:0] half_w;
	logic [HALF_W-1:0] half_h;

	logic [1:0]        state_q;
	logic [2:0]        cnt_q;
	logic [AW-1:0]     base_q;
	logic [SUM_W-1:0]  sum_r_q;
	logic [SUM_W-1:0]  sum_g_q;
	logic [SUM_W-1:0]  sum_b_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [PIX_W-1:0]  mem [DEPTH];
	logic [PIX_W-1:0]  rdata_q;
	logic [AW-1:0]     mem_addr;
	logic              mem_we;
	logic [PIX_W-1:0]  mem_wdata;

	logic              accept;
	logic              load_in_range;
	logic              start;
	logic              busy_x;
	logic              busy_y;
	logic [HALF_W-1:0] rem_x;
	logic [HALF_W-1:0] rem_y;
	logic              out_free;

	function automatic logic [CHAN_W-1:0] bright_sat(input logic [SUM_W-1:0] s,
		input logic [CHAN_W-1:0] amt);
		logic [CHAN_W:0] v;
		v = {1'b0, s[SUM_W-1:2]} + {1'b0, amt};
		return v[CHAN_W] ? CHAN_MAX : v[CHAN_W-1:0];
	endfunction

	always_comb begin
		eff_w = (32'(width_q) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : width_q;
		if (eff_w < SIZE_MIN)
			eff_w = SIZE_MIN;
		eff_h = (32'(height_q) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : height_q;
		if (eff_h < SIZE_MIN)
			eff_h = SIZE_MIN;
	end
	assign half_w = eff_w[SIZE_W-1:1];
	assign half_h = eff_h[SIZE_W-1:1];

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd128;
			height_q <= 8'd128;
			bright_q <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_BRIGHT: bright_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign accept        = in_valid && in_ready;
	assign load_in_range = (in_data.coord_x < {8'd0, eff_w}) &&
		(in_data.coord_y < {8'd0, eff_h});
	assign start         = accept && (in_data.action == ACT_QUERY);
	assign mem_we        = accept && (in_data.action == ACT_LOAD) && load_in_range;
	assign mem_wdata     = {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};

	hstb_rem u_rem_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (in_data.coord_x),
		.divisor  (half_w),
		.busy     (busy_x),
		.rem      (rem_x)
	);

	hstb_rem u_rem_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (in_data.coord_y),
		.divisor  (half_h),
		.busy     (busy_y),
		.rem      (rem_y)
	);

	always_comb begin
		if (mem_we) begin
			mem_addr = AW'(32'(in_data.coord_y) * MAX_WIDTH + 32'(in_data.coord_x));
		end else begin
			case (cnt_q[1:0])
				2'd0:    mem_addr = base_q;
				2'd1:    mem_addr = base_q + AW'(1);
				2'd2:    mem_addr = base_q + AW'(MAX_WIDTH);
				default: mem_addr = base_q + AW'(MAX_WIDTH + 1);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		else
			rdata_q <= mem[mem_addr];
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (!busy_x && !busy_y) begin
						state_q <= ST_RD;
						cnt_q   <= '0;
					end
				end
				ST_RD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd4)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MOD)
			base_q <= AW'(32'({rem_y, 1'b0}) * MAX_WIDTH + 32'({rem_x, 1'b0}));
		if (state_q == ST_MOD) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
		end else if (state_q == ST_RD && cnt_q != 3'd0) begin
			sum_r_q <= sum_r_q + SUM_W'(rdata_q[3*CHAN_W-1:2*CHAN_W]);
			sum_g_q <= sum_g_q + SUM_W'(rdata_q[2*CHAN_W-1:CHAN_W]);
			sum_b_q <= sum_b_q + SUM_W'(rdata_q[CHAN_W-1:0]);
		end
		if (state_q == ST_FIN && out_free) begin
			out_q.out_red   <= bright_sat(sum_r_q, bright_q);
			out_q.out_green <= bright_sat(sum_g_q, bright_q);
			out_q.out_blue  <= bright_sat(sum_b_q, bright_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire
